[hdl/assert_macros.svh]
// assertion macros used by the rtl file bipartite_graph_check.sv
// assumes signals named clock and reset in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BGC_CHECK(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("check failed");
`define BGC_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication failed");
`else
`define BGC_CHECK(label, cond)
`define BGC_IMPLY(label, ante, cons)
`endif
`endif

[hdl/bgc_pkg.sv]
// shared types and constants of the bipartite check
// no dependencies
package bgc_pkg;
   typedef logic [1:0] color_type;
   localparam color_type COLOR_NONE = 2'd0;
   localparam color_type COLOR_ONE  = 2'd1;
   localparam color_type COLOR_TWO  = 2'd2;
endpackage

[hdl/bgc_ram.sv]
// generic simple dual port ram, one write port, one registered read port
// depends on bgc_pkg
module bgc_ram
   import bgc_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[hdl/bipartite_graph_check.sv]
// top level of the bipartite check: edge load, dfs two-coloring, clear
// depends on bgc_pkg, bgc_ram and assert_macros.svh
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | req_mode, req_vertex_a, req_vertex_b
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_bipartite, rsp_input_error
//  csr     | in        | csr_valid / csr_ready  | csr_vertex_count
//
// a load item does two head reads and two entry writes; a rejected one only sets the input error flag
// an evaluate item is run by the single sequencer,
// sharing one port on each of the vertex/edge/stack rams
// after reset a clearing pass over all MAX_VERTICES+1 vertex entries runs before any item is taken
// and the same pass runs after every evaluate, before its result item is shown
// req_stall stays high while an item is in work; the result register holds under rsp_stall
`include "assert_macros.svh"
module bipartite_graph_check
   import bgc_pkg::*;
#(
   parameter int MAX_VERTICES = 256,
   parameter int MAX_EDGES    = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_mode,
   input  logic [8:0] req_vertex_a,
   input  logic [8:0] req_vertex_b,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_bipartite,
   output logic       rsp_input_error,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [8:0] csr_vertex_count
);
   // widths of vertex numbers, links (entry index + 1) and entry indexes
   localparam int VW = $clog2(MAX_VERTICES + 1);
   localparam int ENTRY_CAP = 2 * MAX_EDGES;
   localparam int LW = $clog2(ENTRY_CAP + 1);
   localparam int EW = (ENTRY_CAP > 1) ? $clog2(ENTRY_CAP) : 1;
   localparam int SW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int NW = (VW > 9) ? VW : 9;
   localparam int CW = (NW > VW + 1) ? NW : VW + 1;
   localparam int STW = VW + LW + 2;

   // sequencer states
   localparam logic [3:0] S_CLR    = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_L_RDA  = 4'd2;
   localparam logic [3:0] S_L_WRA  = 4'd3;
   localparam logic [3:0] S_L_RDB  = 4'd4;
   localparam logic [3:0] S_L_WRB  = 4'd5;
   localparam logic [3:0] S_E_SCAN = 4'd6;
   localparam logic [3:0] S_E_CHK  = 4'd7;
   localparam logic [3:0] S_E_EDGE = 4'd8;
   localparam logic [3:0] S_E_POP  = 4'd9;
   localparam logic [3:0] S_E_TGT  = 4'd10;
   localparam logic [3:0] S_E_NB   = 4'd11;
   localparam logic [3:0] S_OUT    = 4'd12;

   logic [3:0]    state_ff, state_in;
   logic [8:0]    cnt_ff, cnt_in;
   logic [VW-1:0] a_ff, a_in, b_ff, b_in;
   logic [LW-1:0] entry_ff, entry_in;
   logic          bip_ff, bip_in, err_ff, err_in, ev_ff, ev_in;
   logic [VW:0]   v_ff, v_in;
   logic [VW-1:0] clr_ff, clr_in;
   logic [VW-1:0] depth_ff, depth_in;
   logic [VW-1:0] top_u_ff, top_u_in;
   logic [LW-1:0] top_link_ff, top_link_in;
   color_type     top_col_ff, top_col_in;
   logic [VW-1:0] w_ff, w_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_bip_ff, rsp_bip_in, rsp_err_ff, rsp_err_in;

   // ram ports
   logic           head_we, color_we, edge_we, stk_we;
   logic [VW-1:0]  head_wa, head_ra, color_wa, color_ra;
   logic [LW-1:0]  head_wd, head_rd;
   color_type      color_wd, color_rd;
   logic [EW-1:0]  edge_wa, edge_ra;
   logic [VW+LW-1:0] edge_wd, edge_rd;
   logic [SW-1:0]  stk_wa, stk_ra;
   logic [STW-1:0] stk_wd, stk_rd;

   logic [NW-1:0] n_eff;
   logic          req_take, bad_edge;
   logic [LW-1:0] link_m1;
   logic [VW-1:0] depth_m1, depth_m2;
   color_type     new_col;

   // vertex count saturates at the store size
   assign n_eff = (NW'(cnt_ff) > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(cnt_ff);
   assign req_stall = (state_ff != S_IDLE);
   assign req_take = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign bad_edge = (req_vertex_a == 9'd0) || (NW'(req_vertex_a) > n_eff)
      || (req_vertex_b == 9'd0) || (NW'(req_vertex_b) > n_eff)
      || (({1'b0, entry_ff} + (LW+1)'(2)) > (LW+1)'(ENTRY_CAP));
   assign link_m1 = top_link_ff - LW'(1);
   assign depth_m1 = depth_ff - VW'(1);
   assign depth_m2 = depth_ff - VW'(2);
   assign new_col = (top_col_ff == COLOR_ONE) ? COLOR_TWO : COLOR_ONE;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_bipartite = rsp_bip_ff;
   assign rsp_input_error = rsp_err_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      a_in = a_ff;
      b_in = b_ff;
      entry_in = entry_ff;
      bip_in = bip_ff;
      err_in = err_ff;
      ev_in = ev_ff;
      v_in = v_ff;
      clr_in = clr_ff;
      depth_in = depth_ff;
      top_u_in = top_u_ff;
      top_link_in = top_link_ff;
      top_col_in = top_col_ff;
      w_in = w_ff;
      rsp_bip_in = rsp_bip_ff;
      rsp_err_in = rsp_err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      head_we = 1'b0;
      head_wa = a_ff;
      head_wd = '0;
      head_ra = a_ff;
      color_we = 1'b0;
      color_wa = v_ff[VW-1:0];
      color_wd = COLOR_NONE;
      color_ra = v_ff[VW-1:0];
      edge_we = 1'b0;
      edge_wa = entry_ff[EW-1:0];
      edge_wd = '0;
      edge_ra = link_m1[EW-1:0];
      stk_we = 1'b0;
      stk_wa = depth_m1[SW-1:0];
      stk_wd = {top_u_ff, top_link_ff, top_col_ff};
      stk_ra = depth_m2[SW-1:0];

      if (csr_valid) begin
         cnt_in = csr_vertex_count;
      end

      case (state_ff)
         S_CLR: begin
            // wipe list heads and colors, one vertex a cycle
            head_we = 1'b1;
            head_wa = clr_ff;
            color_we = 1'b1;
            color_wa = clr_ff;
            clr_in = clr_ff + VW'(1);
            if (clr_ff == VW'(MAX_VERTICES)) begin
               entry_in = '0;
               state_in = ev_ff ? S_OUT : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               if (req_mode) begin
                  v_in = (VW+1)'(1);
                  ev_in = 1'b1;
                  state_in = S_E_SCAN;
               end else if (bad_edge) begin
                  err_in = 1'b1;
               end else begin
                  a_in = VW'(req_vertex_a);
                  b_in = VW'(req_vertex_b);
                  state_in = S_L_RDA;
               end
            end
         end
         S_L_RDA: begin
            head_ra = a_ff;
            state_in = S_L_WRA;
         end
         S_L_WRA: begin
            edge_we = 1'b1;
            edge_wd = {b_ff, head_rd};
            head_we = 1'b1;
            head_wa = a_ff;
            head_wd = entry_ff + LW'(1);
            entry_in = entry_ff + LW'(1);
            state_in = S_L_RDB;
         end
         S_L_RDB: begin
            // separate read so a self-loop sees the head just written
            head_ra = b_ff;
            state_in = S_L_WRB;
         end
         S_L_WRB: begin
            edge_we = 1'b1;
            edge_wd = {a_ff, head_rd};
            head_we = 1'b1;
            head_wa = b_ff;
            head_wd = entry_ff + LW'(1);
            entry_in = entry_ff + LW'(1);
            state_in = S_IDLE;
         end
         S_E_SCAN: begin
            if (CW'(v_ff) > CW'(n_eff)) begin
               clr_in = '0;
               state_in = S_CLR;
            end else begin
               color_ra = v_ff[VW-1:0];
               head_ra = v_ff[VW-1:0];
               state_in = S_E_CHK;
            end
         end
         S_E_CHK: begin
            if (color_rd != COLOR_NONE) begin
               v_in = v_ff + (VW+1)'(1);
               state_in = S_E_SCAN;
            end else begin
               // new root of a component
               color_we = 1'b1;
               color_wa = v_ff[VW-1:0];
               color_wd = COLOR_ONE;
               top_u_in = v_ff[VW-1:0];
               top_link_in = head_rd;
               top_col_in = COLOR_ONE;
               depth_in = VW'(1);
               state_in = S_E_EDGE;
            end
         end
         S_E_EDGE: begin
            if (top_link_ff == '0) begin
               if (depth_ff == VW'(1)) begin
                  v_in = v_ff + (VW+1)'(1);
                  state_in = S_E_SCAN;
               end else begin
                  stk_ra = depth_m2[SW-1:0];
                  depth_in = depth_m1;
                  state_in = S_E_POP;
               end
            end else begin
               edge_ra = link_m1[EW-1:0];
               state_in = S_E_TGT;
            end
         end
         S_E_POP: begin
            {top_u_in, top_link_in, top_col_in} = stk_rd;
            state_in = S_E_EDGE;
         end
         S_E_TGT: begin
            w_in = edge_rd[VW+LW-1:LW];
            top_link_in = edge_rd[LW-1:0];
            color_ra = edge_rd[VW+LW-1:LW];
            head_ra = edge_rd[VW+LW-1:LW];
            state_in = S_E_NB;
         end
         S_E_NB: begin
            if (color_rd == COLOR_NONE) begin
               // unvisited neighbor: color opposite, descend
               color_we = 1'b1;
               color_wa = w_ff;
               color_wd = new_col;
               if (depth_ff < VW'(MAX_VERTICES)) begin
                  stk_we = 1'b1;
                  stk_wa = depth_m1[SW-1:0];
                  top_u_in = w_ff;
                  top_link_in = head_rd;
                  top_col_in = new_col;
                  depth_in = depth_ff + VW'(1);
               end
            end else if (color_rd == top_col_ff) begin
               bip_in = 1'b0;
            end
            state_in = S_E_EDGE;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_bip_in = bip_ff;
               rsp_err_in = err_ff;
               bip_in = 1'b1;
               err_in = 1'b0;
               ev_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         cnt_ff <= 9'd256;
         entry_ff <= '0;
         bip_ff <= 1'b1;
         err_ff <= 1'b0;
         ev_ff <= 1'b0;
         clr_ff <= '0;
         depth_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         entry_ff <= entry_in;
         bip_ff <= bip_in;
         err_ff <= err_in;
         ev_ff <= ev_in;
         clr_ff <= clr_in;
         depth_ff <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      v_ff <= v_in;
      top_u_ff <= top_u_in;
      top_link_ff <= top_link_in;
      top_col_ff <= top_col_in;
      w_ff <= w_in;
      rsp_bip_ff <= rsp_bip_in;
      rsp_err_ff <= rsp_err_in;
   end

   // list heads, one per vertex
   bgc_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES + 1)) u_head (
      .clock(clock), .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
      .rd_addr(head_ra), .rd_data(head_rd)
   );

   // colors, nonzero means visited
   bgc_ram #(.WIDTH(2), .DEPTH(MAX_VERTICES + 1)) u_color (
      .clock(clock), .wr_en(color_we), .wr_addr(color_wa), .wr_data(color_wd),
      .rd_addr(color_ra), .rd_data(color_rd)
   );

   // adjacency entries: target vertex and next link
   bgc_ram #(.WIDTH(VW + LW), .DEPTH(ENTRY_CAP)) u_edge (
      .clock(clock), .wr_en(edge_we), .wr_addr(edge_wa), .wr_data(edge_wd),
      .rd_addr(edge_ra), .rd_data(edge_rd)
   );

   // walk stack below the top level, which lives in registers
   bgc_ram #(.WIDTH(STW), .DEPTH(MAX_VERTICES)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
      .rd_addr(stk_ra), .rd_data(stk_rd)
   );

   `BGC_CHECK(a_entry_cap, ({1'b0, entry_ff} <= (LW+1)'(ENTRY_CAP)))
   `BGC_IMPLY(a_walk_depth, (state_ff == S_E_EDGE || state_ff == S_E_NB), (depth_ff != '0))
   `BGC_IMPLY(a_rsp_hold, (rsp_valid_ff && rsp_stall), (rsp_valid_in && rsp_bip_in == rsp_bip_ff))
endmodule

[verif/testbench.sv]
// self-checking testbench of bipartite_graph_check: edge loads, evaluate items, csr writes
// depends on bgc_pkg and the bipartite_graph_check rtl
module testbench
   import bgc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_V = 256;
   localparam int MAX_E = 1024;
   localparam bit MODE_LOAD = 1'b0;
   localparam bit MODE_EVAL = 1'b1;

   typedef struct packed {
      logic bipartite;
      logic input_error;
   } verdict_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_mode = 1'b0;
   logic [8:0] req_vertex_a = '0;
   logic [8:0] req_vertex_b = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_bipartite;
   logic       rsp_input_error;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [8:0] csr_vertex_count = '0;

   int  error_count = 0;
   int  eval_count = 0;
   int  load_count = 0;
   bit  idle_enable = 1'b1;
   bit  hold_off = 1'b0;

   bipartite_graph_check i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_vertex_a(req_vertex_a), .req_vertex_b(req_vertex_b),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_bipartite(rsp_bipartite), .rsp_input_error(rsp_input_error),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_vertex_count(csr_vertex_count)
   );

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %0s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // predictor of the coloring walk plus the queue of verdicts still owed
   class verdict_board;
      int unsigned vertex_limit = 256;
      color_type   color[MAX_V+1];
      bit          seen[MAX_V+1];
      int unsigned head[MAX_V+1];
      int unsigned target[2*MAX_E];
      int unsigned link_next[2*MAX_E];
      int unsigned entries;
      bit          two_colorable;
      bit          dropped;
      int unsigned stack_v[MAX_V];
      int unsigned stack_c[MAX_V];
      verdict_type owed[$];

      function new();
         wipe();
      endfunction

      function void wipe();
         foreach (color[i]) begin
            color[i] = COLOR_NONE;
            seen[i] = 1'b0;
            head[i] = 0;
         end
         entries = 0;
         two_colorable = 1'b1;
         dropped = 1'b0;
      endfunction

      function void add_entry(int unsigned from, int unsigned to);
         target[entries] = to;
         link_next[entries] = head[from];
         head[from] = entries + 1;
         entries++;
      endfunction

      function void walk(int unsigned root);
         int unsigned depth;
         int unsigned u;
         int unsigned lnk;
         int unsigned w;
         depth = 1;
         seen[root] = 1'b1;
         if (color[root] == COLOR_NONE) color[root] = COLOR_ONE;
         stack_v[0] = root;
         stack_c[0] = head[root];
         while (depth > 0) begin
            u = stack_v[depth-1];
            lnk = stack_c[depth-1];
            if (lnk == 0 || lnk > entries) begin
               depth--;
               continue;
            end
            w = target[lnk-1];
            stack_c[depth-1] = link_next[lnk-1];
            if (w > MAX_V) continue;
            if (!seen[w]) begin
               color[w] = (color[u] == COLOR_ONE) ? COLOR_TWO : COLOR_ONE;
               seen[w] = 1'b1;
               if (depth < MAX_V) begin
                  stack_v[depth] = w;
                  stack_c[depth] = head[w];
                  depth++;
               end
            end
            if (color[u] == color[w]) two_colorable = 1'b0;
         end
      endfunction

      // note one accepted input item
      function void note_item(bit mode, int unsigned a, int unsigned b);
         int unsigned n;
         verdict_type v;
         n = (vertex_limit > MAX_V) ? MAX_V : vertex_limit;
         if (mode == MODE_LOAD) begin
            if (a == 0 || a > n || b == 0 || b > n || entries + 2 > 2*MAX_E)
               dropped = 1'b1;
            else begin
               add_entry(a, b);
               add_entry(b, a);
            end
         end else begin
            for (int unsigned x = 1; x <= n; x++)
               if (!seen[x]) walk(x);
            v.bipartite = two_colorable;
            v.input_error = dropped;
            owed.push_back(v);
            wipe();
         end
      endfunction

      // compare one accepted result item with the oldest owed verdict
      task check_result(logic bip, logic err);
         verdict_type v;
         if (owed.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
            return;
         end
         v = owed.pop_front();
         if (bip !== v.bipartite) report_mismatch("bipartite", bip, v.bipartite);
         if (err !== v.input_error) report_mismatch("input_error", err, v.input_error);
      endtask
   endclass

   verdict_board board = new();

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #80ms;
      $display("CHECK FAILED");
      $finish;
   end

   // result side: sample at rising edge, stall changes at falling edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_result(rsp_bipartite, rsp_input_error);
         eval_count++;
      end
   end

   initial begin
      int hold;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            // long hold-off so the block fills and pushes back on the sender
            rsp_stall <= 1'b1;
            hold = 0;
            while (hold < 3000) begin
               @(negedge clock);
               hold++;
            end
            hold_off = 1'b0;
         end
         rsp_stall <= idle_enable && ($urandom_range(99) < 20);
      end
   end

   // send one item and wait for acceptance; valid stays up for a back-to-back item
   task automatic send_item(bit mode, int unsigned a, int unsigned b);
      while (idle_enable && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_vertex_a <= a[8:0];
      req_vertex_b <= b[8:0];
      do @(posedge clock); while (req_stall);
      board.note_item(mode, a, b);
      if (mode == MODE_LOAD) load_count++;
      @(negedge clock);
   endtask

   task automatic drain();
      int guard;
      req_valid <= 1'b0;
      guard = 0;
      while (board.owed.size() != 0 && guard < 2000000) begin
         @(negedge clock);
         guard++;
      end
      // a trailing load may still be in work
      repeat (20) @(negedge clock);
   endtask

   task automatic write_count(int unsigned value);
      drain();
      csr_valid <= 1'b1;
      csr_vertex_count <= value[8:0];
      do @(posedge clock); while (!csr_ready);
      board.vertex_limit = value & 9'h1ff;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one random graph: mostly legal edges, some out of range, often a bipartite layering
   task automatic random_graph(int unsigned n, int unsigned edges);
      int unsigned a;
      int unsigned b;
      bit layered;
      layered = $urandom_range(1);
      for (int i = 0; i < edges; i++) begin
         a = $urandom_range(1, n);
         b = $urandom_range(1, n);
         if (layered && ((a ^ b) & 1) == 0) b = (b == n) ? ((n > 1) ? n - 1 : 1) : b + 1;
         if ($urandom_range(99) < 5) a = $urandom_range(0, 511);
         if ($urandom_range(99) < 3) b = $urandom_range(0, 511);
         send_item(MODE_LOAD, a, b);
      end
      send_item(MODE_EVAL, $urandom_range(0, 511), $urandom_range(0, 511));
   endtask

   initial begin
      int unsigned n;
      @(negedge clock);
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed: empty graph, self-loop, an odd cycle, range extremes
      send_item(MODE_EVAL, 0, 0);
      send_item(MODE_LOAD, 1, 256);
      send_item(MODE_LOAD, 256, 2);
      send_item(MODE_EVAL, 0, 0);
      send_item(MODE_LOAD, 5, 5);
      send_item(MODE_EVAL, 511, 511);
      send_item(MODE_LOAD, 1, 2);
      send_item(MODE_LOAD, 2, 3);
      send_item(MODE_LOAD, 3, 1);
      send_item(MODE_EVAL, 0, 0);
      send_item(MODE_LOAD, 0, 1);
      send_item(MODE_LOAD, 1, 257);
      send_item(MODE_LOAD, 511, 511);
      send_item(MODE_LOAD, 3, 4);
      send_item(MODE_EVAL, 0, 0);

      // zero vertices, then one vertex
      write_count(0);
      send_item(MODE_LOAD, 1, 1);
      send_item(MODE_EVAL, 0, 0);
      write_count(1);
      send_item(MODE_LOAD, 1, 1);
      send_item(MODE_EVAL, 0, 0);

      // saturation above the maximum, then lowering after load
      write_count(511);
      send_item(MODE_LOAD, 200, 256);
      drain();
      write_count(4);
      send_item(MODE_LOAD, 1, 200);
      send_item(MODE_EVAL, 0, 0);

      // a long path that drives the walk deep into the stack
      write_count(256);
      for (int i = 0; i < 180; i++)
         send_item(MODE_LOAD, (i % 255) + 1, (i % 255) + 2);
      send_item(MODE_EVAL, 0, 0);

      // random phases over several vertex counts, with pressure in one
      for (int phase = 0; phase < 12; phase++) begin
         n = (phase % 4 == 0) ? 256 : $urandom_range(2, 16);
         write_count(n);
         if (phase == 3) idle_enable = 1'b0;
         if (phase == 5) begin
            idle_enable = 1'b1;
            hold_off = 1'b1;
         end
         for (int g = 0; g < 8; g++)
            random_graph(n, $urandom_range(0, (n > 16) ? 12 : 6));
      end
      write_count(256);

      drain();
      $display("ran %0d edge loads and %0d evaluations over several vertex counts",
         load_count, eval_count);
      if (error_count == 0 && board.owed.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

[files.f]
+incdir+hdl
hdl/bgc_pkg.sv
hdl/bgc_ram.sv
hdl/bipartite_graph_check.sv
verif/testbench.sv
